>>> sv/etk_pkg.sv
// Shared types and constants for the expression tokenizer.
// Depends on nothing; used by etk_scan and expression_tokenizer.
`default_nettype none

package etk_pkg;

    localparam longint unsigned ETK_MAX_TEXT_CHARS = 64'd65536;

    localparam int ETK_VALUE_W = 63;
    localparam int ETK_OFS_W   = 16;
    localparam int ETK_SLOTS   = 3;

    localparam logic [ETK_VALUE_W-1:0] ETK_VALUE_MAX = {ETK_VALUE_W{1'b1}};

    localparam logic [7:0] ETK_CH_PLUS   = 8'h2B;
    localparam logic [7:0] ETK_CH_MINUS  = 8'h2D;
    localparam logic [7:0] ETK_CH_LPAREN = 8'h28;
    localparam logic [7:0] ETK_CH_RPAREN = 8'h29;
    localparam logic [7:0] ETK_CH_ZERO   = 8'h30;

    typedef enum logic [2:0] {
        KIND_NUMBER   = 3'd0,
        KIND_OPERATOR = 3'd1,
        KIND_NAME     = 3'd2,
        KIND_LPAREN   = 3'd3,
        KIND_RPAREN   = 3'd4,
        KIND_EOF      = 3'd5,
        KIND_ERROR    = 3'd6
    } kind_t;

    typedef struct packed {
        kind_t                  kind;
        logic [ETK_VALUE_W-1:0] number_value;
        logic                   overflow;
        logic [ETK_OFS_W-1:0]   token_start;
        logic [ETK_OFS_W-1:0]   token_length;
        logic [7:0]             token_char;
        logic                   last_of_run;
    } token_t;

    function automatic token_t make_tok(
        input kind_t                  kind,
        input logic [ETK_VALUE_W-1:0] value,
        input logic                   ovf,
        input logic [ETK_OFS_W-1:0]   start,
        input logic [ETK_OFS_W-1:0]   len,
        input logic [7:0]             c
    );
        token_t t;
        t.kind         = kind;
        t.number_value = value;
        t.overflow     = ovf;
        t.token_start  = start;
        t.token_length = len;
        t.token_char   = c;
        t.last_of_run  = 1'b0;
        return t;
    endfunction

endpackage

`default_nettype wire

>>> sv/expression_tokenizer.sv
// Top level of the expression tokenizer: input register, scanner, result buffer.
// Depends on etk_pkg and etk_scan.
//
//   channel | direction | word                        | handshake
//   --------+-----------+-----------------------------+-----------------
//   s_      | in        | one character + end flag    | s_valid/s_ready
//   m_      | out       | one token                   | m_valid/m_ready
//
// One character per cycle is taken when each yields at most one token and
// m_ready stays high; a character that yields several tokens holds the
// scanner until the result buffer, draining one word per cycle while m_ready
// is high, is down to its last token. The first token passes through the input
// register, then the result buffer, before it is offered on the m_ channel.
// Reset clears the scanner state, the input valid and the buffer count.
// A stall on m_ready backs up through the buffer into s_ready.
`default_nettype none

module expression_tokenizer
    import etk_pkg::*;
#(
    parameter longint unsigned MAX_TEXT_CHARS = ETK_MAX_TEXT_CHARS
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // character input
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [7:0]             s_ch,
    input  wire logic                   s_end_of_text,
    // token output
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [2:0]                  m_kind,
    output logic [ETK_VALUE_W-1:0]      m_number_value,
    output logic                        m_overflow,
    output logic [ETK_OFS_W-1:0]        m_token_start,
    output logic [ETK_OFS_W-1:0]        m_token_length,
    output logic [7:0]                  m_token_char,
    output logic                        m_last_of_run
);

    // input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] ch_reg;
    logic       eot_reg;

    // result buffer: slot 0 drives the m_ ports
    token_t     slot_reg [ETK_SLOTS];
    token_t     slot_next [ETK_SLOTS];
    logic [1:0] count_reg, count_next;

    token_t     new_tok [ETK_SLOTS];
    logic [1:0] new_count;
    logic       pop;
    logic       take;

    etk_scan #(
        .MAX_TEXT_CHARS(MAX_TEXT_CHARS)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .take      (take),
        .ch        (ch_reg),
        .eot       (eot_reg),
        .tok       (new_tok),
        .tok_count (new_count)
    );

    assign m_valid = (count_reg != 2'd0);
    assign pop     = m_valid && m_ready;

    // Advance the scanner only when the buffer is empty after this cycle's pop.
    assign take    = in_valid_reg
                     && ((count_reg == 2'd0) || ((count_reg == 2'd1) && m_ready));
    assign s_ready = !in_valid_reg || take;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (take) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        slot_next  = slot_reg;
        count_next = count_reg;
        if (take) begin
            // load the whole batch; a character with no tokens leaves it empty
            slot_next  = new_tok;
            count_next = new_count;
        end else if (pop) begin
            // shift toward the output slot
            for (int i = 0; i < ETK_SLOTS - 1; i++) begin
                slot_next[i] = slot_reg[i+1];
            end
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            count_reg    <= 2'd0;
        end else begin
            in_valid_reg <= in_valid_next;
            count_reg    <= count_next;
        end
    end

    // Hold payload; no reset needed.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            ch_reg  <= s_ch;
            eot_reg <= s_end_of_text;
        end
        slot_reg <= slot_next;
    end

    assign m_kind         = slot_reg[0].kind;
    assign m_number_value = slot_reg[0].number_value;
    assign m_overflow     = slot_reg[0].overflow;
    assign m_token_start  = slot_reg[0].token_start;
    assign m_token_length = slot_reg[0].token_length;
    assign m_token_char   = slot_reg[0].token_char;
    assign m_last_of_run  = slot_reg[0].last_of_run;

endmodule

`default_nettype wire

>>> sv/etk_scan.sv
// Scanner core: lexer state and the up to three tokens one character yields.
// Depends on etk_pkg.
`default_nettype none

module etk_scan
    import etk_pkg::*;
#(
    parameter longint unsigned MAX_TEXT_CHARS = ETK_MAX_TEXT_CHARS
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       take,
    input  wire logic [7:0] ch,
    input  wire logic       eot,
    output token_t          tok [ETK_SLOTS],
    output logic [1:0]      tok_count
);

    localparam int POS_W = $clog2(MAX_TEXT_CHARS);
    localparam logic [POS_W:0] LIMIT = MAX_TEXT_CHARS[POS_W:0];

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_NUM,
        MODE_NAME,
        MODE_DISCARD
    } mode_t;

    mode_t                  mode_reg,  mode_next;
    logic [POS_W-1:0]       pos_reg,   pos_next;
    logic [POS_W-1:0]       start_reg, start_next;
    logic [ETK_VALUE_W-1:0] acc_reg,   acc_next;
    logic                   sat_reg,   sat_next;

    function automatic logic [ETK_OFS_W-1:0] span(
        input logic [POS_W-1:0] s,
        input logic [POS_W-1:0] e
    );
        logic [POS_W:0] d;
        d = {1'b0, e} - {1'b0, s};
        if (e < s) begin
            d = d + LIMIT;
        end
        return ETK_OFS_W'(d[POS_W-1:0]);
    endfunction

    always_comb begin
        logic [POS_W:0]         inc;
        logic [POS_W-1:0]       npos;
        logic [ETK_VALUE_W+3:0] prod;
        logic                   is_digit, is_alpha, is_space;
        token_t                 t [ETK_SLOTS];
        logic [1:0]             n;

        inc  = {1'b0, pos_reg} + 1'b1;
        npos = (inc >= LIMIT) ? '0 : inc[POS_W-1:0];

        is_digit = ch inside {[8'h30:8'h39]};
        is_alpha = ch inside {[8'h41:8'h5A], [8'h61:8'h7A]};
        is_space = ch inside {8'h20, [8'h09:8'h0D]};

        // acc * 10 + digit, wide enough to see the saturation point
        prod = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
             + (ETK_VALUE_W+4)'(ch - ETK_CH_ZERO);

        mode_next  = mode_reg;
        pos_next   = pos_reg;
        start_next = start_reg;
        acc_next   = acc_reg;
        sat_next   = sat_reg;
        n          = 2'd0;
        for (int i = 0; i < ETK_SLOTS; i++) begin
            t[i] = make_tok(KIND_EOF, '0, 1'b0, '0, '0, '0);
        end

        if (mode_reg == MODE_DISCARD) begin
            if (eot) begin
                mode_next  = MODE_IDLE;
                pos_next   = '0;
                start_next = '0;
                acc_next   = '0;
                sat_next   = 1'b0;
            end else begin
                pos_next = npos;
            end
        end else begin
            // close a pending number or name on the character that ends it
            if (mode_reg == MODE_NUM) begin
                if (is_digit) begin
                    if (prod[ETK_VALUE_W+3:ETK_VALUE_W] != '0) begin
                        acc_next = ETK_VALUE_MAX;
                        sat_next = 1'b1;
                    end else begin
                        acc_next = prod[ETK_VALUE_W-1:0];
                    end
                end else begin
                    t[n] = make_tok(KIND_NUMBER, acc_reg, sat_reg,
                                    ETK_OFS_W'(start_reg), span(start_reg, pos_reg), '0);
                    n = n + 2'd1;
                    mode_next = MODE_IDLE;
                end
            end else if (mode_reg == MODE_NAME) begin
                if (!is_alpha && !is_digit) begin
                    t[n] = make_tok(KIND_NAME, '0, 1'b0,
                                    ETK_OFS_W'(start_reg), span(start_reg, pos_reg), '0);
                    n = n + 2'd1;
                    mode_next = MODE_IDLE;
                end
            end

            if (mode_next == MODE_IDLE) begin
                if (is_space) begin
                    // skip
                end else if (is_digit) begin
                    mode_next  = MODE_NUM;
                    start_next = pos_reg;
                    acc_next   = ETK_VALUE_W'(ch - ETK_CH_ZERO);
                    sat_next   = 1'b0;
                end else if (ch == ETK_CH_PLUS || ch == ETK_CH_MINUS) begin
                    t[n] = make_tok(KIND_OPERATOR, '0, 1'b0, ETK_OFS_W'(pos_reg),
                                    ETK_OFS_W'(1), ch);
                    n = n + 2'd1;
                end else if (is_alpha) begin
                    mode_next  = MODE_NAME;
                    start_next = pos_reg;
                end else if (ch == ETK_CH_LPAREN) begin
                    t[n] = make_tok(KIND_LPAREN, '0, 1'b0, ETK_OFS_W'(pos_reg),
                                    ETK_OFS_W'(1), '0);
                    n = n + 2'd1;
                end else if (ch == ETK_CH_RPAREN) begin
                    t[n] = make_tok(KIND_RPAREN, '0, 1'b0, ETK_OFS_W'(pos_reg),
                                    ETK_OFS_W'(1), '0);
                    n = n + 2'd1;
                end else begin
                    t[n] = make_tok(KIND_ERROR, '0, 1'b0, ETK_OFS_W'(pos_reg),
                                    ETK_OFS_W'(1), ch);
                    n = n + 2'd1;
                    mode_next = MODE_DISCARD;
                end
            end

            if (eot) begin
                if (mode_next != MODE_DISCARD) begin
                    if (mode_next == MODE_NUM) begin
                        t[n] = make_tok(KIND_NUMBER, acc_next, sat_next,
                                        ETK_OFS_W'(start_next), span(start_next, npos), '0);
                        n = n + 2'd1;
                    end else if (mode_next == MODE_NAME) begin
                        t[n] = make_tok(KIND_NAME, '0, 1'b0,
                                        ETK_OFS_W'(start_next), span(start_next, npos), '0);
                        n = n + 2'd1;
                    end
                    t[n] = make_tok(KIND_EOF, '0, 1'b0, ETK_OFS_W'(npos), '0, '0);
                    n = n + 2'd1;
                end
                mode_next  = MODE_IDLE;
                pos_next   = '0;
                start_next = '0;
                acc_next   = '0;
                sat_next   = 1'b0;
            end else begin
                pos_next = npos;
            end
        end

        for (int i = 0; i < ETK_SLOTS; i++) begin
            t[i].last_of_run = (2'(i) == n - 2'd1);
        end

        tok       = t;
        tok_count = n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            pos_reg   <= '0;
            start_reg <= '0;
            acc_reg   <= '0;
            sat_reg   <= 1'b0;
        end else if (take) begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            acc_reg   <= acc_next;
            sat_reg   <= sat_next;
        end
    end

endmodule

`default_nettype wire
